// ----- hw/rtl/bgld_pkg.sv -----
// Shared types and constants for the button gesture / LED blink dimmer block.
// No dependencies; imported by every module of the block.
package bgld_pkg;

  // Default build sizes
  localparam int unsigned NUM_LEDS_DEF  = 6;
  localparam int unsigned PWM_STEPS_DEF = 100;

  // Field and counter widths
  localparam int unsigned IDX_W       = 3;   // LED number 1..7
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned PIN_W       = 6;   // one drive bit per LED 1..6
  localparam int unsigned BRIGHT_W    = 6;
  localparam int unsigned PHASE_W     = 7;   // PWM phase, steps up to 127
  localparam int unsigned ON_W        = 8;   // duty threshold, up to 63*127/32
  localparam int unsigned PROD_W      = BRIGHT_W + PHASE_W;
  localparam int unsigned BRIGHT_DIV_SH = 5; // duty scale divides by 32
  localparam int unsigned PRESS_CNT_W = 16;
  localparam int unsigned BLINK_CNT_W = 20;
  localparam int unsigned CLICK_W     = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SLOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MID  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_FAST = 3'd5;

  // Register reset values
  localparam logic [PRESS_CNT_W-1:0] DEBOUNCE_RST   = 16'd200;
  localparam logic [PRESS_CNT_W-1:0] CLICK_WIN_RST  = 16'd400;
  localparam logic [PRESS_CNT_W-1:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [BLINK_CNT_W-1:0] BLINK_SLOW_RST = 20'd500000;
  localparam logic [BLINK_CNT_W-1:0] BLINK_MID_RST  = 20'd100000;
  localparam logic [BLINK_CNT_W-1:0] BLINK_FAST_RST = 20'd50000;

  // Blink modes
  localparam logic [MODE_W-1:0] MODE_SLOW = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MID  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAST = 2'd2;

  // Click counts
  localparam logic [CLICK_W-1:0] CLICKS_NONE   = 2'd0;
  localparam logic [CLICK_W-1:0] CLICKS_SINGLE = 2'd1;
  localparam logic [CLICK_W-1:0] CLICKS_DOUBLE = 2'd2;

  // Configuration register set
  typedef struct packed {
    logic [PRESS_CNT_W-1:0] debounce;
    logic [PRESS_CNT_W-1:0] click_win;
    logic [PRESS_CNT_W-1:0] long_press;
    logic [BLINK_CNT_W-1:0] blink_slow;
    logic [BLINK_CNT_W-1:0] blink_mid;
    logic [BLINK_CNT_W-1:0] blink_fast;
  } cfg_t;

  // Selection state after the press update of one transfer
  typedef struct packed {
    logic              output_enable;
    logic [IDX_W-1:0]  led_index;
    logic [MODE_W-1:0] mode;
  } sel_t;

endpackage

// ----- hw/rtl/bgld_press.sv -----
// Press timing and gesture classification, mode table and LED selection.
// Depends on bgld_pkg.
module bgld_press
  import bgld_pkg::*;
#(
  parameter int unsigned NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  logic press_tick,
  input  logic button_level,
  input  cfg_t cfg,
  output sel_t sel_nxt
);

  logic                   press_active_r, press_active_nxt;
  logic [PRESS_CNT_W-1:0] press_ticks_r, press_ticks_nxt;
  logic [CLICK_W-1:0]     clicks_r, clicks_nxt;
  logic                   latched_r, latched_nxt;
  logic                   enable_r, enable_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [MODE_W-1:0]      mode_r   [NUM_LEDS];
  logic [MODE_W-1:0]      mode_nxt [NUM_LEDS];
  logic                   bump;
  logic [IDX_W-1:0]       slot, slot_nxt;
  logic [MODE_W-1:0]      sel_mode;

  // Gesture classification on a press tick
  always_comb begin
    press_active_nxt = press_active_r;
    press_ticks_nxt  = press_ticks_r;
    clicks_nxt       = clicks_r;
    latched_nxt      = latched_r;
    enable_nxt       = enable_r;
    idx_nxt          = idx_r;
    bump             = 1'b0;
    if (press_tick) begin
      if (!button_level) begin
        press_active_nxt = 1'b1;
      end
      if (press_active_nxt) begin
        if (press_ticks_r != {PRESS_CNT_W{1'b1}}) begin
          press_ticks_nxt = press_ticks_r + 1'b1;
        end
        // inside the click window: first or second press seen
        if (press_ticks_nxt < cfg.click_win && press_ticks_nxt > cfg.debounce &&
            !latched_r) begin
          if (!button_level) begin
            latched_nxt = 1'b1;
            clicks_nxt  = CLICKS_DOUBLE;
          end else begin
            clicks_nxt  = CLICKS_SINGLE;
          end
        end
        // window closed with the button up: act on the click
        if (press_ticks_nxt > cfg.click_win && button_level) begin
          if (clicks_nxt >= CLICKS_DOUBLE) begin
            latched_nxt = 1'b0;
            bump        = 1'b1;
          end else begin
            enable_nxt = ~enable_r;
          end
          clicks_nxt       = CLICKS_NONE;
          press_active_nxt = 1'b0;
          press_ticks_nxt  = '0;
        end
        // long hold: next LED, wrapping to the first
        if (press_ticks_nxt > cfg.long_press && !button_level) begin
          clicks_nxt       = CLICKS_NONE;
          press_active_nxt = 1'b0;
          press_ticks_nxt  = '0;
          latched_nxt      = 1'b0;
          if (idx_r == IDX_W'(NUM_LEDS)) begin
            idx_nxt = IDX_W'(1);
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
    end
  end

  assign slot     = idx_r - 1'b1;
  assign slot_nxt = idx_nxt - 1'b1;

  // Mode step per entry, then read at the new selection
  always_comb begin
    sel_mode = '0;
    for (int e = 0; e < NUM_LEDS; e++) begin
      mode_nxt[e] = mode_r[e];
      if (bump && slot == IDX_W'(e)) begin
        case (mode_r[e])
          MODE_SLOW: mode_nxt[e] = MODE_MID;
          MODE_MID:  mode_nxt[e] = MODE_FAST;
          MODE_FAST: mode_nxt[e] = MODE_SLOW;
          default:   mode_nxt[e] = MODE_MID;
        endcase
      end
      if (slot_nxt == IDX_W'(e)) begin
        sel_mode = mode_nxt[e];
      end
    end
  end

  assign sel_nxt.output_enable = enable_nxt;
  assign sel_nxt.led_index     = idx_nxt;
  assign sel_nxt.mode          = sel_mode;

  // State registers, updated once per input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_active_r <= 1'b0;
      press_ticks_r  <= '0;
      clicks_r       <= CLICKS_NONE;
      latched_r      <= 1'b0;
      enable_r       <= 1'b0;
      idx_r          <= IDX_W'(1);
      for (int e = 0; e < NUM_LEDS; e++) begin
        mode_r[e] <= MODE_SLOW;
      end
    end else if (step_en) begin
      press_active_r <= press_active_nxt;
      press_ticks_r  <= press_ticks_nxt;
      clicks_r       <= clicks_nxt;
      latched_r      <= latched_nxt;
      enable_r       <= enable_nxt;
      idx_r          <= idx_nxt;
      for (int e = 0; e < NUM_LEDS; e++) begin
        mode_r[e] <= mode_nxt[e];
      end
    end
  end

endmodule

// ----- hw/rtl/bgld_pwm.sv -----
// Blink timer, PWM phase counter and LED drive for the selected LED.
// Depends on bgld_pkg; takes the post-press selection from bgld_press.
module bgld_pwm
  import bgld_pkg::*;
#(
  parameter int unsigned PWM_STEPS = PWM_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                pwm_tick,
  input  logic [BRIGHT_W-1:0] brightness,
  input  cfg_t                cfg,
  input  sel_t                sel,
  output logic [PIN_W-1:0]    led_pins_nxt
);

  localparam logic [PHASE_W-1:0] STEPS = PHASE_W'(PWM_STEPS);

  logic [BLINK_CNT_W-1:0] blink_ticks_r, blink_ticks_nxt;
  logic                   blink_phase_r, blink_phase_nxt;
  logic [PHASE_W-1:0]     pwm_phase_r, pwm_phase_nxt;
  logic [PIN_W-1:0]       drive_r;
  logic [PROD_W-1:0]      prod;
  logic [ON_W-1:0]        on_level;
  logic [BLINK_CNT_W-1:0] limit;
  logic                   has_limit;
  logic [IDX_W-1:0]       slot;
  logic [PIN_W-1:0]       onehot;

  // Duty threshold: brightness * steps / 32
  assign prod     = {{PHASE_W{1'b0}}, brightness} * {{BRIGHT_W{1'b0}}, STEPS};
  assign on_level = prod[PROD_W-1:BRIGHT_DIV_SH];

  assign slot = sel.led_index - 1'b1;

  // One drive bit per LED; a seventh LED has no pin
  always_comb begin
    for (int k = 0; k < PIN_W; k++) begin
      onehot[k] = (slot == IDX_W'(k));
    end
  end

  // Half period of the selected mode
  always_comb begin
    limit     = '0;
    has_limit = 1'b1;
    case (sel.mode)
      MODE_SLOW: limit = cfg.blink_slow;
      MODE_MID:  limit = cfg.blink_mid;
      MODE_FAST: limit = cfg.blink_fast;
      default:   has_limit = 1'b0;
    endcase
  end

  // Blink and PWM update on a PWM tick
  always_comb begin
    blink_ticks_nxt = blink_ticks_r;
    blink_phase_nxt = blink_phase_r;
    pwm_phase_nxt   = pwm_phase_r;
    led_pins_nxt    = drive_r;
    if (pwm_tick) begin
      if (blink_ticks_r != {BLINK_CNT_W{1'b1}}) begin
        blink_ticks_nxt = blink_ticks_r + 1'b1;
      end
      pwm_phase_nxt = pwm_phase_r + 1'b1;
      if (has_limit && blink_ticks_nxt > limit) begin
        blink_ticks_nxt = '0;
        blink_phase_nxt = ~blink_phase_r;
      end
      if (blink_phase_nxt && sel.output_enable &&
          {1'b0, pwm_phase_nxt} <= on_level) begin
        led_pins_nxt = onehot;
      end else begin
        led_pins_nxt = '0;
      end
      if (pwm_phase_nxt >= STEPS) begin
        pwm_phase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_ticks_r <= '0;
      blink_phase_r <= 1'b0;
      pwm_phase_r   <= '0;
      drive_r       <= '0;
    end else if (step_en) begin
      blink_ticks_r <= blink_ticks_nxt;
      blink_phase_r <= blink_phase_nxt;
      pwm_phase_r   <= pwm_phase_nxt;
      drive_r       <= led_pins_nxt;
    end
  end

endmodule

// ----- hw/rtl/button_gesture_led_blink_dimmer_core.sv -----
// Button gesture detector with LED blink and dimmer: top level.
// Instantiates bgld_press and bgld_pwm; depends on bgld_pkg.
//
// Usage: each input transfer is one tick carrying a press-timer strobe, a
// PWM-timer strobe, the active-low button level and a brightness value.
// Every input transfer yields exactly one result transfer carrying the LED
// drive, output enable, selected LED and its blink mode.
// Latency: the result is presented the cycle after the input transfer.
// Throughput: one transfer per cycle while the receiver does not stall; the
// state update is a single pass of compares and increments between the state
// registers and the result register.
// The result register decouples the channels: in_ready stays high while
// the result register is empty or being drained, so a new input is taken in
// the same cycle an older result is handed over. When the receiver stalls
// with a result held, in_ready drops and the result stays unchanged.
// Reset (rst_n low, synchronous): timing registers return to their reset
// values, LED 1 is selected, all modes are slow, output is disabled and the
// result register is emptied. Configuration writes are taken at once on
// cfg_we and should only be made while the block is idle.
module button_gesture_led_blink_dimmer_core
  import bgld_pkg::*;
#(
  parameter int unsigned NUM_LEDS  = NUM_LEDS_DEF,
  parameter int unsigned PWM_STEPS = PWM_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_press_tick,
  input  logic                  in_pwm_tick,
  input  logic                  in_button_level,
  input  logic [BRIGHT_W-1:0]   in_brightness,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIN_W-1:0]      out_led_pins,
  output logic                  out_enable_status,
  output logic [IDX_W-1:0]      out_led_index,
  output logic [MODE_W-1:0]     out_active_mode
);

  cfg_t              cfg_r;
  sel_t              sel_nxt;
  logic [PIN_W-1:0]  led_pins_nxt;
  logic              step_en;
  logic              out_valid_r;
  logic [PIN_W-1:0]  led_pins_r;
  logic              enable_r;
  logic [IDX_W-1:0]  led_index_r;
  logic [MODE_W-1:0] mode_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step_en  = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.click_win  <= CLICK_WIN_RST;
      cfg_r.long_press <= LONG_PRESS_RST;
      cfg_r.blink_slow <= BLINK_SLOW_RST;
      cfg_r.blink_mid  <= BLINK_MID_RST;
      cfg_r.blink_fast <= BLINK_FAST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg_r.debounce   <= cfg_wdata[PRESS_CNT_W-1:0];
        CFG_CLICK_WIN:  cfg_r.click_win  <= cfg_wdata[PRESS_CNT_W-1:0];
        CFG_LONG_PRESS: cfg_r.long_press <= cfg_wdata[PRESS_CNT_W-1:0];
        CFG_BLINK_SLOW: cfg_r.blink_slow <= cfg_wdata[BLINK_CNT_W-1:0];
        CFG_BLINK_MID:  cfg_r.blink_mid  <= cfg_wdata[BLINK_CNT_W-1:0];
        CFG_BLINK_FAST: cfg_r.blink_fast <= cfg_wdata[BLINK_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Press work runs first; its selection feeds the PWM work
  bgld_press #(
    .NUM_LEDS (NUM_LEDS)
  ) u_press (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .press_tick   (in_press_tick),
    .button_level (in_button_level),
    .cfg          (cfg_r),
    .sel_nxt      (sel_nxt)
  );

  bgld_pwm #(
    .PWM_STEPS (PWM_STEPS)
  ) u_pwm (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .pwm_tick     (in_pwm_tick),
    .brightness   (in_brightness),
    .cfg          (cfg_r),
    .sel          (sel_nxt),
    .led_pins_nxt (led_pins_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      led_pins_r  <= led_pins_nxt;
      enable_r    <= sel_nxt.output_enable;
      led_index_r <= sel_nxt.led_index;
      mode_r      <= sel_nxt.mode;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_pins      = led_pins_r;
  assign out_enable_status = enable_r;
  assign out_led_index     = led_index_r;
  assign out_active_mode   = mode_r;

endmodule

// ----- hw/rtl/bgld_chk.sv -----
// Port-level checker for the button gesture / LED blink dimmer top level,
// and the bind that attaches it. Depends on bgld_pkg.
module bgld_chk
  import bgld_pkg::*;
#(
  parameter int unsigned NUM_LEDS = NUM_LEDS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PIN_W-1:0]  out_led_pins,
  input logic [IDX_W-1:0]  out_led_index,
  input logic [MODE_W-1:0] out_active_mode
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_pins) &&
    $stable(out_led_index) && $stable(out_active_mode))
    else $error("stalled result changed");

  // an empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // selected LED stays within 1..NUM_LEDS
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_led_index != '0 && out_led_index <= IDX_W'(NUM_LEDS))
    else $error("selected LED out of range");

  // at most one LED driven, and only the mode codes in use
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_led_pins) && out_active_mode <= MODE_FAST)
    else $error("bad LED drive or mode");

endmodule

bind button_gesture_led_blink_dimmer_core bgld_chk #(
  .NUM_LEDS (NUM_LEDS)
) u_bgld_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_led_pins    (out_led_pins),
  .out_led_index   (out_led_index),
  .out_active_mode (out_active_mode)
);

// ----- bench/tb_button_gesture_led_blink_dimmer_core.sv -----
// Self-checking testbench for button_gesture_led_blink_dimmer_core.
// Holds its own gesture and blink predictor, drives both channels with random stalls.
// Depends on bgld_pkg and the core RTL only.
module tb_button_gesture_led_blink_dimmer_core;
  import bgld_pkg::*;

  localparam int unsigned LEDS       = NUM_LEDS_DEF;
  localparam int unsigned STEPS      = PWM_STEPS_DEF;
  localparam int          DOG_LIMIT  = 2000;
  localparam int          PRINT_CAP  = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;  // no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [CFG_DATA_W-1:0] DATA_ALL_ONES = {CFG_DATA_W{1'b1}};

  // One input tick and one lamp result
  typedef struct packed {
    logic                press;
    logic                pwm;
    logic                level;
    logic [BRIGHT_W-1:0] bright;
  } tick_t;

  typedef struct packed {
    logic [PIN_W-1:0]  pins;
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [MODE_W-1:0] mode;
  } lamp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_press_tick = 1'b0;
  logic                  in_pwm_tick = 1'b0;
  logic                  in_button_level = 1'b1;
  logic [BRIGHT_W-1:0]   in_brightness = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIN_W-1:0]      out_led_pins;
  logic                  out_enable_status;
  logic [IDX_W-1:0]      out_led_index;
  logic [MODE_W-1:0]     out_active_mode;

  button_gesture_led_blink_dimmer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_press_tick    (in_press_tick),
    .in_pwm_tick      (in_pwm_tick),
    .in_button_level  (in_button_level),
    .in_brightness    (in_brightness),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_pins     (out_led_pins),
    .out_enable_status(out_enable_status),
    .out_led_index    (out_led_index),
    .out_active_mode  (out_active_mode)
  );

  always #1 clk = ~clk;

  // Predictor state and register copy
  cfg_t                   timing;
  logic                   hold_active;
  logic [PRESS_CNT_W-1:0] hold_count;
  logic [CLICK_W-1:0]     press_clicks;
  logic                   second_latched;
  logic                   out_en;
  logic [IDX_W-1:0]       led_sel;
  logic [MODE_W-1:0]      blink_mode [LEDS];
  logic [BLINK_CNT_W-1:0] blink_count;
  logic                   blink_on;
  logic [PHASE_W-1:0]     pwm_count;
  logic [PIN_W-1:0]       pin_drive;

  lamp_t lamp_q[$];
  lamp_t lamp_want;
  int    err_count = 0;
  int    lamps_checked = 0;
  int    ticks_sent = 0;
  int    strobe_ticks = 0;
  int    reg_writes = 0;
  int    idle_cycles = 0;
  int    in_gap_pct = 0;
  int    out_stall_pct = 0;

  function automatic int unsigned slot_of(input logic [IDX_W-1:0] sel);
    return (sel < 1 || sel > LEDS) ? 0 : sel - 1;
  endfunction

  // Press classification then blink/dimmer, in that order
  function automatic lamp_t predict_lamp(input tick_t t);
    int unsigned        slot;
    int unsigned        duty;
    logic [BLINK_CNT_W-1:0] half;
    logic               has_half;
    lamp_t              r;
    if (t.press) begin
      if (!t.level) hold_active = 1'b1;
      if (hold_active) begin
        if (hold_count != {PRESS_CNT_W{1'b1}}) hold_count = hold_count + 1'b1;
        if (hold_count < timing.click_win && hold_count > timing.debounce &&
            !second_latched) begin
          if (!t.level) begin
            second_latched = 1'b1;
            press_clicks = CLICKS_DOUBLE;
          end else begin
            press_clicks = CLICKS_SINGLE;
          end
        end
        if (hold_count > timing.click_win && t.level) begin
          if (press_clicks >= CLICKS_DOUBLE) begin
            slot = slot_of(led_sel);
            second_latched = 1'b0;
            blink_mode[slot] = (blink_mode[slot] == MODE_FAST) ? MODE_SLOW :
                               blink_mode[slot] + 1'b1;
          end else begin
            out_en = ~out_en;
          end
          press_clicks = CLICKS_NONE;
          hold_active = 1'b0;
          hold_count  = '0;
        end
        if (hold_count > timing.long_press && !t.level) begin
          press_clicks   = CLICKS_NONE;
          hold_active    = 1'b0;
          hold_count     = '0;
          second_latched = 1'b0;
          led_sel = (led_sel >= LEDS) ? IDX_W'(1) : led_sel + 1'b1;
        end
      end
    end
    if (t.pwm) begin
      duty = (int'(t.bright) * STEPS) / 32;
      slot = slot_of(led_sel);
      if (blink_count != {BLINK_CNT_W{1'b1}}) blink_count = blink_count + 1'b1;
      pwm_count = pwm_count + 1'b1;
      has_half = 1'b1;
      half = '0;
      case (blink_mode[slot])
        MODE_SLOW: half = timing.blink_slow;
        MODE_MID:  half = timing.blink_mid;
        MODE_FAST: half = timing.blink_fast;
        default:   has_half = 1'b0;
      endcase
      if (has_half && blink_count > half) begin
        blink_count = '0;
        blink_on = ~blink_on;
      end
      pin_drive = '0;
      if (blink_on && out_en && pwm_count <= duty && slot < PIN_W) pin_drive[slot] = 1'b1;
      if (pwm_count >= STEPS) pwm_count = '0;
    end
    r.pins = pin_drive;
    r.en   = out_en;
    r.idx  = led_sel;
    r.mode = blink_mode[slot_of(led_sel)];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("mismatch on %s: got %0d, expected %0d (result %0d)",
               what, got, want, lamps_checked);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (lamp_q.size() == 0) begin
        report_mismatch("unexpected result", out_led_index, 0);
      end else begin
        lamp_want = lamp_q.pop_front();
        if (out_led_pins !== lamp_want.pins)
          report_mismatch("led_pins", out_led_pins, lamp_want.pins);
        if (out_enable_status !== lamp_want.en)
          report_mismatch("enable_status", out_enable_status, lamp_want.en);
        if (out_led_index !== lamp_want.idx)
          report_mismatch("led_index", out_led_index, lamp_want.idx);
        if (out_active_mode !== lamp_want.mode)
          report_mismatch("active_mode", out_active_mode, lamp_want.mode);
        lamps_checked++;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= DOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", DOG_LIMIT);
      $display("tb_button_gesture_led_blink_dimmer_core: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one tick; valid is left high for a back-to-back follower
  task automatic send_tick(input logic press, input logic pwm, input logic level,
                           input logic [BRIGHT_W-1:0] bright);
    tick_t t;
    t = '{press: press, pwm: pwm, level: level, bright: bright};
    if ($urandom_range(0, 99) < in_gap_pct) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_press_tick   <= press;
    in_pwm_tick     <= pwm;
    in_button_level <= level;
    in_brightness   <= bright;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lamp_q.push_back(predict_lamp(t));
    ticks_sent++;
    if (press || pwm) strobe_ticks++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Register write; the block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE:   timing.debounce   = data[PRESS_CNT_W-1:0];
      CFG_CLICK_WIN:  timing.click_win  = data[PRESS_CNT_W-1:0];
      CFG_LONG_PRESS: timing.long_press = data[PRESS_CNT_W-1:0];
      CFG_BLINK_SLOW: timing.blink_slow = data;
      CFG_BLINK_MID:  timing.blink_mid  = data;
      CFG_BLINK_FAST: timing.blink_fast = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_timing(input int deb, input int win, input int lng,
                             input int slow, input int mid, input int fast);
    hold_until_drained();
    write_reg(CFG_DEBOUNCE,   CFG_DATA_W'(deb));
    write_reg(CFG_CLICK_WIN,  CFG_DATA_W'(win));
    write_reg(CFG_LONG_PRESS, CFG_DATA_W'(lng));
    write_reg(CFG_BLINK_SLOW, CFG_DATA_W'(slow));
    write_reg(CFG_BLINK_MID,  CFG_DATA_W'(mid));
    write_reg(CFG_BLINK_FAST, CFG_DATA_W'(fast));
  endtask

  // Press ticks at one level, with stray non-press ticks mixed in
  task automatic press_run(input logic level, input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  BRIGHT_W'($urandom_range(0, 63)));
      send_tick(1'b1, 1'($urandom_range(0, 1)), level, BRIGHT_W'($urandom_range(0, 63)));
    end
  endtask

  // Reset values, then click, double click and long press with tiny thresholds
  task automatic test_directed();
    send_tick(1'b0, 1'b0, 1'b1, 6'd0);
    send_tick(1'b0, 1'b1, 1'b1, 6'd63);
    send_tick(1'b0, 1'b1, 1'b0, 6'd0);
    load_timing(1, 4, 6, 1, 0, 2);
    // single click toggles enable
    send_tick(1'b1, 1'b0, 1'b0, 6'd17);
    repeat (5) send_tick(1'b1, 1'b1, 1'b1, 6'd63);
    // held past debounce: mode step
    repeat (3) send_tick(1'b1, 1'b0, 1'b0, 6'd32);
    repeat (2) send_tick(1'b1, 1'b1, 1'b1, 6'd10);
    // long hold advances the LED, then a release with no press active
    repeat (7) send_tick(1'b1, 1'b1, 1'b0, 6'd63);
    send_tick(1'b1, 1'b0, 1'b1, 6'd0);
  endtask

  // Zero long-press threshold: every held tick advances, wrapping past the last LED
  task automatic test_led_wrap();
    hold_until_drained();
    write_reg(CFG_LONG_PRESS, CFG_DATA_W'(0));
    repeat (LEDS + 1) send_tick(1'b1, 1'b1, 1'b0, BRIGHT_W'($urandom_range(0, 63)));
    send_tick(1'b1, 1'b0, 1'b1, 6'd5);
  endtask

  // Mostly well-formed gestures with random timing, some bounce noise
  task automatic test_random_gestures(input int target);
    int start;
    int kind;
    start = ticks_sent;
    while (ticks_sent - start < target) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: press_run(1'b0, $urandom_range(1, timing.debounce + 1));
        3, 4, 5: press_run(1'b0, $urandom_range(timing.debounce + 1, timing.click_win));
        6, 7:    press_run(1'b0, $urandom_range(timing.long_press - 1,
                                                timing.long_press + 2));
        8:       repeat ($urandom_range(1, 10)) press_run(1'($urandom_range(0, 1)), 1);
        default: repeat ($urandom_range(1, 6))
                   send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             BRIGHT_W'($urandom_range(0, 63)));
      endcase
      press_run(1'b1, $urandom_range(0, timing.click_win + 3));
      if ($urandom_range(0, 49) == 0) hold_until_drained();
    end
  endtask

  // Thresholds at their maximum never fire; a threshold just below the count then fires
  task automatic test_counter_limits();
    hold_until_drained();
    write_reg(CFG_DEBOUNCE,   DATA_ALL_ONES);
    write_reg(CFG_CLICK_WIN,  DATA_ALL_ONES);
    write_reg(CFG_LONG_PRESS, DATA_ALL_ONES);
    write_reg(CFG_BLINK_SLOW, DATA_ALL_ONES);
    write_reg(CFG_BLINK_MID,  DATA_ALL_ONES);
    write_reg(CFG_BLINK_FAST, DATA_ALL_ONES);
    repeat (100) send_tick(1'b1, 1'b1, 1'b0, BRIGHT_W'($urandom_range(0, 63)));
    send_tick(1'b1, 1'b1, 1'b1, 6'd40);
    hold_until_drained();
    write_reg(CFG_LONG_PRESS, CFG_DATA_W'(hold_count));
    repeat (2) send_tick(1'b1, 1'b1, 1'b0, 6'd63);
  endtask

  initial begin
    timing = '{debounce: DEBOUNCE_RST, click_win: CLICK_WIN_RST,
               long_press: LONG_PRESS_RST, blink_slow: BLINK_SLOW_RST,
               blink_mid: BLINK_MID_RST, blink_fast: BLINK_FAST_RST};
    hold_active    = 1'b0;
    hold_count     = '0;
    press_clicks   = CLICKS_NONE;
    second_latched = 1'b0;
    out_en         = 1'b0;
    led_sel        = IDX_W'(1);
    foreach (blink_mode[i]) blink_mode[i] = MODE_SLOW;
    blink_count = '0;
    blink_on    = 1'b0;
    pwm_count   = '0;
    pin_drive   = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    in_gap_pct = 14;
    out_stall_pct = 85;
    test_directed();
    test_led_wrap();
    load_timing(2, 8, 20, 3, 5, 1);
    test_random_gestures(600);

    in_gap_pct = 85;
    out_stall_pct = 14;
    load_timing(0, 5, 12, 0, 7, 2);
    write_reg(CFG_SPARE_LO, 20'd1);
    write_reg(CFG_SPARE_HI, DATA_ALL_ONES);
    test_random_gestures(600);

    in_gap_pct = 0;
    out_stall_pct = 0;
    load_timing(4, 12, 30, 10, 4, 6);
    test_random_gestures(600);
    test_counter_limits();

    @(negedge clk);
    in_valid <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("run: %0d ticks (%0d with a strobe), %0d results checked, %0d register writes",
             ticks_sent, strobe_ticks, lamps_checked, reg_writes);
    $display("covered clicks, held and long presses, LED wrap, maximum thresholds, three stall mixes");
    if (err_count == 0)
      $display("tb_button_gesture_led_blink_dimmer_core: clean");
    else
      $display("tb_button_gesture_led_blink_dimmer_core: errors");
    $finish;
  end

endmodule

// ----- button_gesture_led_blink_dimmer_core.f -----
hw/rtl/bgld_pkg.sv
hw/rtl/bgld_press.sv
hw/rtl/bgld_pwm.sv
hw/rtl/button_gesture_led_blink_dimmer_core.sv
hw/rtl/bgld_chk.sv
bench/tb_button_gesture_led_blink_dimmer_core.sv
